// ===== src/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int COL_W      = 7;
    localparam int LINE_W     = 6;
    localparam int X_W        = 7;
    localparam int Y_W        = 6;
    localparam int OFF_W      = 13;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int ROWS_CFG_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_PUT_CHAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_CELL  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR    = 2'd2;

    localparam int                COLUMNS_RESET = 80;
    localparam int                ROWS_RESET    = 25;
    localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'h0F;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CELL_W-1:0] SCROLL_BLANK = 16'h0720;
    localparam logic [CELL_W-1:0] CLEAR_BLANK  = 16'h0F20;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADVANCE,
        S_NEWLINE,
        S_SCROLL,
        S_CLEAR,
        S_SETCUR,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [X_W-1:0]    cursor_x;
        logic [Y_W-1:0]    cursor_y;
        logic [OFF_W-1:0]  cursor_offset;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic              error;
    } t_result;

endpackage

// ===== src/tcw_ram.sv =====
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 8192,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tcw_seq.sv =====
`timescale 1ns / 1ps

module tcw_seq #(
    parameter int  MAX_COLUMNS = 128,
    parameter int  MAX_ROWS    = 64,
    parameter int  TAB_WIDTH   = 8,
    localparam int CVW         = $clog2(MAX_COLUMNS + 1),
    localparam int RVW         = $clog2(MAX_ROWS + 1),
    localparam int AW          = $clog2(MAX_COLUMNS * MAX_ROWS),
    localparam int TW          = $clog2(MAX_COLUMNS * MAX_ROWS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tcw_pkg::CMD_W-1:0]      i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]      i_column,
    input  logic [tcw_pkg::LINE_W-1:0]     i_line,
    input  logic [CVW-1:0]                 i_cols,
    input  logic [RVW-1:0]                 i_rows,
    input  logic [TW-1:0]                  i_total,
    input  logic [AW-1:0]                  i_last_base,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_attr,
    input  logic                           i_home,
    output logic                           o_done,
    output tcw_pkg::t_result               o_res,
    input  logic                           i_res_free,
    output logic                           o_mem_we,
    output logic [AW-1:0]                  o_mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]     o_mem_wdata,
    output logic [AW-1:0]                  o_mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]     i_mem_rdata
);

    import tcw_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int TCW = $clog2(TAB_WIDTH + 1);
    localparam int PW  = CVW + LINE_W + 1;

    t_state              r_state;
    t_state              n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [CHAR_W-1:0]   r_ch;
    logic [COL_W-1:0]    r_col_in;
    logic [LINE_W-1:0]   r_line_in;
    logic [CW-1:0]       r_cur_col;
    logic [RW-1:0]       r_cur_row;
    logic [AW-1:0]       r_cur_off;
    logic [TCW-1:0]      r_adv_cnt;
    logic                r_store;
    logic [TW-1:0]       r_ptr;
    logic                r_wr_vld;
    logic                r_wr_blank;
    logic [AW-1:0]       r_wr_ptr;
    logic [AW-1:0]       r_pos_off;
    logic                r_err;
    logic [CELL_W-1:0]   r_cell;

    logic                w_inside;
    logic [PW-1:0]       w_pos;
    logic                w_col_end;
    logic                w_row_end;
    logic [TW-1:0]       w_src;
    logic [TW-1:0]       w_ptr_inc;
    logic [RVW-1:0]      w_rows_m1;
    logic [TW-1:0]       w_nl_off;
    logic                w_sweep_done;
    logic                w_clear_last;
    logic                w_scroll_blank;

    assign w_inside       = (32'(r_col_in) < 32'(i_cols)) && (32'(r_line_in) < 32'(i_rows));
    assign w_pos          = PW'(i_cols) * PW'(r_line_in) + PW'(r_col_in);
    assign w_col_end      = (CVW'(r_cur_col) + CVW'(1)) >= i_cols;
    assign w_row_end      = (RVW'(r_cur_row) + RVW'(1)) >= i_rows;
    assign w_src          = r_ptr + TW'(i_cols);
    assign w_ptr_inc      = r_ptr + TW'(1);
    assign w_rows_m1      = i_rows - RVW'(1);
    assign w_nl_off       = TW'(r_cur_off) - TW'(r_cur_col) + TW'(i_cols);
    assign w_sweep_done   = (r_ptr == i_total);
    assign w_clear_last   = (w_ptr_inc == i_total);
    assign w_scroll_blank = (r_ptr >= TW'(i_last_base));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_cmd)
                    CMD_PUT_CHAR:   n_state = (r_ch == CH_NEWLINE) ? S_NEWLINE : S_ADVANCE;
                    CMD_SET_CURSOR: n_state = S_SETCUR;
                    CMD_CLEAR:      n_state = S_CLEAR;
                    CMD_READ_CELL:  n_state = w_inside ? S_READ : S_DONE;
                    default:        n_state = S_DONE;
                endcase
            end
            S_ADVANCE: begin
                if (w_col_end && w_row_end) begin
                    n_state = S_SCROLL;
                end else if (r_adv_cnt == TCW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_NEWLINE: n_state = w_row_end ? S_SCROLL : S_DONE;
            S_SCROLL: begin
                if (w_sweep_done) begin
                    n_state = (r_adv_cnt == '0) ? S_DONE : S_ADVANCE;
                end
            end
            S_CLEAR: begin
                if (w_clear_last) begin
                    n_state = S_DONE;
                end
            end
            S_SETCUR:    n_state = S_DONE;
            S_READ:      n_state = S_READ_WAIT;
            S_READ_WAIT: n_state = S_DONE;
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_done      = (r_state == S_DONE);
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cur_off;
        o_mem_wdata = {i_attr, r_ch};
        o_mem_raddr = r_pos_off;
        case (r_state)
            S_ADVANCE: o_mem_we = r_store;
            S_SCROLL: begin
                o_mem_raddr = w_src[AW-1:0];
                o_mem_we    = r_wr_vld;
                o_mem_waddr = r_wr_ptr;
                o_mem_wdata = r_wr_blank ? SCROLL_BLANK : i_mem_rdata;
            end
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr[AW-1:0];
                o_mem_wdata = CLEAR_BLANK;
            end
            default: o_mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_cur_off <= '0;
            r_adv_cnt <= '0;
            r_store   <= 1'b0;
            r_ptr     <= '0;
            r_wr_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_home) begin
                r_cur_col <= '0;
                r_cur_row <= '0;
                r_cur_off <= '0;
            end else begin
                case (r_state)
                    S_DECODE: begin
                        r_ptr <= '0;
                        if (r_cmd == CMD_PUT_CHAR) begin
                            r_store <= (r_ch != CH_NEWLINE) && (r_ch != CH_TAB);
                            if (r_ch == CH_NEWLINE) begin
                                r_adv_cnt <= '0;
                            end else if (r_ch == CH_TAB) begin
                                r_adv_cnt <= TCW'(TAB_WIDTH);
                            end else begin
                                r_adv_cnt <= TCW'(1);
                            end
                        end else if (r_cmd == CMD_CLEAR) begin
                            r_cur_col <= '0;
                            r_cur_row <= '0;
                            r_cur_off <= '0;
                        end
                    end
                    S_ADVANCE: begin
                        r_store   <= 1'b0;
                        r_adv_cnt <= r_adv_cnt - TCW'(1);
                        if (w_col_end && w_row_end) begin
                            r_cur_col <= '0;
                            r_cur_row <= w_rows_m1[RW-1:0];
                            r_cur_off <= i_last_base;
                            r_ptr     <= '0;
                        end else if (w_col_end) begin
                            r_cur_col <= '0;
                            r_cur_row <= r_cur_row + RW'(1);
                            r_cur_off <= r_cur_off + AW'(1);
                        end else begin
                            r_cur_col <= r_cur_col + CW'(1);
                            r_cur_off <= r_cur_off + AW'(1);
                        end
                    end
                    S_NEWLINE: begin
                        if (w_row_end) begin
                            r_cur_col <= '0;
                            r_cur_row <= w_rows_m1[RW-1:0];
                            r_cur_off <= i_last_base;
                            r_ptr     <= '0;
                        end else begin
                            r_cur_col <= '0;
                            r_cur_row <= r_cur_row + RW'(1);
                            r_cur_off <= w_nl_off[AW-1:0];
                        end
                    end
                    S_SCROLL: begin
                        r_wr_vld <= !w_sweep_done;
                        if (!w_sweep_done) begin
                            r_ptr <= w_ptr_inc;
                        end
                    end
                    S_CLEAR: r_ptr <= w_ptr_inc;
                    S_SETCUR: begin
                        if (w_inside) begin
                            r_cur_col <= CW'(r_col_in);
                            r_cur_row <= RW'(r_line_in);
                            r_cur_off <= r_pos_off;
                        end
                    end
                    default: r_wr_vld <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_cmd     <= i_command;
                    r_ch      <= i_char_code;
                    r_col_in  <= i_column;
                    r_line_in <= i_line;
                end
            end
            S_DECODE: begin
                r_pos_off <= w_pos[AW-1:0];
                r_err     <= ((r_cmd == CMD_SET_CURSOR) || (r_cmd == CMD_READ_CELL)) && !w_inside;
                r_cell    <= '0;
            end
            S_SCROLL: begin
                r_wr_ptr   <= r_ptr[AW-1:0];
                r_wr_blank <= w_scroll_blank;
            end
            S_READ_WAIT: r_cell <= i_mem_rdata;
            default: r_cell <= r_cell;
        endcase
    end

    always_comb begin
        o_res.cursor_x      = X_W'(r_cur_col);
        o_res.cursor_y      = Y_W'(r_cur_row);
        o_res.cursor_offset = OFF_W'(r_cur_off);
        o_res.cell_char     = r_cell[CHAR_W-1:0];
        o_res.cell_attr     = r_cell[CELL_W-1:CHAR_W];
        o_res.error         = r_err;
    end

endmodule

// ===== src/text_console_writer_unit.sv =====
`timescale 1ns / 1ps

// Text console writer: keeps a screen of character/attribute cells in one
// simple dual-port RAM and a cursor in registers, and answers each command
// beat with exactly one result beat. Commands are taken one at a time. A
// tab steps the cursor TAB_WIDTH times; an out-of-range read_cell skips the
// RAM read, and a valid one waits for the registered RAM read output. A
// scroll and clear_screen both walk the store one cell per cycle through the
// single write port. A result beat that is not taken holds the next command.
// The screen store is not cleared after reset, so issue clear_screen before
// reading cells back. Writing columns or rows homes the cursor.
module text_console_writer_unit #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int TAB_WIDTH   = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tcw_pkg::CMD_W-1:0]        i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]        i_column,
    input  logic [tcw_pkg::LINE_W-1:0]       i_line,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tcw_pkg::X_W-1:0]          o_cursor_x,
    output logic [tcw_pkg::Y_W-1:0]          o_cursor_y,
    output logic [tcw_pkg::OFF_W-1:0]        o_cursor_offset,
    output logic [tcw_pkg::CHAR_W-1:0]       o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]       o_cell_attr,
    output logic                             o_error,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import tcw_pkg::*;

    localparam int DEPTH    = MAX_COLUMNS * MAX_ROWS;
    localparam int CVW      = $clog2(MAX_COLUMNS + 1);
    localparam int RVW      = $clog2(MAX_ROWS + 1);
    localparam int AW       = $clog2(DEPTH);
    localparam int TW       = $clog2(DEPTH + 1);
    localparam int GW       = CVW + RVW;
    localparam int COLS_RST = (COLUMNS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLUMNS_RESET;
    localparam int ROWS_RST = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

    logic [CVW-1:0]      r_cols;
    logic [RVW-1:0]      r_rows;
    logic [ATTR_W-1:0]   r_attr;
    logic [CVW-1:0]      n_cols;
    logic [RVW-1:0]      n_rows;
    logic [TW-1:0]       r_total;
    logic [AW-1:0]       r_last_base;
    logic [GW-1:0]       w_total;
    logic [GW-1:0]       w_last_base;
    logic                w_home;

    logic                r_out_vld;
    t_result             r_out;
    logic                w_done;
    t_result             w_res;
    logic                w_out_free;

    logic                w_mem_we;
    logic [AW-1:0]       w_mem_waddr;
    logic [CELL_W-1:0]   w_mem_wdata;
    logic [AW-1:0]       w_mem_raddr;
    logic [CELL_W-1:0]   w_mem_rdata;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_cols = CVW'(1);
        end else if (32'(i_cfg_data) > MAX_COLUMNS) begin
            n_cols = CVW'(MAX_COLUMNS);
        end else begin
            n_cols = CVW'(i_cfg_data);
        end
        if (i_cfg_data[ROWS_CFG_W-1:0] == '0) begin
            n_rows = RVW'(1);
        end else if (32'(i_cfg_data[ROWS_CFG_W-1:0]) > MAX_ROWS) begin
            n_rows = RVW'(MAX_ROWS);
        end else begin
            n_rows = RVW'(i_cfg_data[ROWS_CFG_W-1:0]);
        end
    end

    assign w_home = i_cfg_we && ((i_cfg_index == CFG_COLUMNS) || (i_cfg_index == CFG_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CVW'(COLS_RST);
            r_rows <= RVW'(ROWS_RST);
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_cols <= n_cols;
                CFG_ROWS:    r_rows <= n_rows;
                CFG_ATTR:    r_attr <= i_cfg_data;
                default:     r_attr <= r_attr;
            endcase
        end
    end

    assign w_total     = GW'(r_cols) * GW'(r_rows);
    assign w_last_base = GW'(r_cols) * GW'(r_rows - RVW'(1));

    always_ff @(posedge i_clk) begin
        r_total     <= w_total[TW-1:0];
        r_last_base <= w_last_base[AW-1:0];
    end

    tcw_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_WIDTH   (TAB_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_column    (i_column),
        .i_line      (i_line),
        .i_cols      (r_cols),
        .i_rows      (r_rows),
        .i_total     (r_total),
        .i_last_base (r_last_base),
        .i_attr      (r_attr),
        .i_home      (w_home),
        .o_done      (w_done),
        .o_res       (w_res),
        .i_res_free  (w_out_free),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // hold the result beat until taken
    assign w_out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_done && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_cursor_x      = r_out.cursor_x;
    assign o_cursor_y      = r_out.cursor_y;
    assign o_cursor_offset = r_out.cursor_offset;
    assign o_cell_char     = r_out.cell_char;
    assign o_cell_attr     = r_out.cell_attr;
    assign o_error         = r_out.error;

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && !w_out_free |=> w_done)
        else $error("finished result dropped while output slot busy");

    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && w_out_free |=> o_out_valid && !w_done)
        else $error("finished result not moved to output register");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command accepted while previous one in progress");

endmodule
